// ===== rtl/core/ple_pkg.sv =====
// Package for the positional list engine: sizes, command and status codes,
// and the control bundle broadcast to the storage cells. No dependencies.
package ple_pkg;

   // List capacity and derived widths.
   localparam int DEPTH       = 16;
   localparam int CELL_IDX_W  = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);

   // Field widths of the item channels.
   localparam int CMD_W       = 2;
   localparam int VALUE_W     = 32;
   localparam int POS_W       = 5;
   localparam int STATUS_W    = 2;
   localparam int ENTRY_CNT_W = 5;

   // Compare width for position checks against the entry count.
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT  = 2'd0,
      CMD_DELETE  = 2'd1,
      CMD_READOUT = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_EMPTY   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_READOUT
   } state_type;

   // Control broadcast from the controller to every cell in the chain.
   typedef struct packed {
      cell_op_type               op;
      logic [CELL_IDX_W-1:0]     pos_idx;
      logic [CELL_IDX_W-1:0]     last_idx;
      logic signed [VALUE_W-1:0] value;
   } cell_ctrl_type;

   // Result item held in the output register.
   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [VALUE_W-1:0] read_value;
      logic [ENTRY_CNT_W-1:0]    entry_count;
      logic                      last_result;
   } rsp_payload_type;

endpackage

// ===== rtl/core/ple_req_if.sv =====
// Request channel of the positional list engine: valid/ready plus command.
// Depends on ple_pkg for field widths.
interface ple_req_if;
   logic                               valid;
   logic                               ready;
   logic [ple_pkg::CMD_W-1:0]          cmd;
   logic signed [ple_pkg::VALUE_W-1:0] item_value;
   logic [ple_pkg::POS_W-1:0]          position;

   modport source (output valid, output cmd, output item_value, output position,
                   input ready);
   modport sink   (input valid, input cmd, input item_value, input position,
                   output ready);
endinterface

// ===== rtl/core/ple_rsp_if.sv =====
// Response channel of the positional list engine: valid/ready plus result.
// Depends on ple_pkg for field widths.
interface ple_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [ple_pkg::STATUS_W-1:0]       status;
   logic signed [ple_pkg::VALUE_W-1:0] read_value;
   logic [ple_pkg::ENTRY_CNT_W-1:0]    entry_count;
   logic                               last_result;

   modport source (output valid, output status, output read_value,
                   output entry_count, output last_result, input ready);
   modport sink   (input valid, input status, input read_value,
                   input entry_count, input last_result, output ready);
endinterface

// ===== rtl/core/ple_cell.sv =====
// One storage cell of the list chain. Holds a single entry and takes its
// next value from itself, its neighbors, the head cell or the broadcast. Depends on ple_pkg.
module ple_cell (
   input  logic                               clock,
   input  ple_pkg::cell_ctrl_type             ctrl,
   input  logic [ple_pkg::CELL_IDX_W-1:0]     cell_index,
   input  logic signed [ple_pkg::VALUE_W-1:0] left_value,
   input  logic signed [ple_pkg::VALUE_W-1:0] right_value,
   input  logic signed [ple_pkg::VALUE_W-1:0] head_value,
   output logic signed [ple_pkg::VALUE_W-1:0] value
);

   logic signed [ple_pkg::VALUE_W-1:0] value_ff;
   logic signed [ple_pkg::VALUE_W-1:0] value_in;

   // Select the next entry: shift back on insert, forward on delete, and
   // rotate the occupied part of the chain during a readout.
   always_comb begin
      value_in = value_ff;
      unique case (ctrl.op)
         ple_pkg::CELL_INSERT: begin
            if (cell_index == ctrl.pos_idx) begin
               value_in = ctrl.value;
            end else if (cell_index > ctrl.pos_idx) begin
               value_in = left_value;
            end
         end
         ple_pkg::CELL_DELETE: begin
            if (cell_index >= ctrl.pos_idx) begin
               value_in = right_value;
            end
         end
         ple_pkg::CELL_ROTATE: begin
            if (cell_index < ctrl.last_idx) begin
               value_in = right_value;
            end else if (cell_index == ctrl.last_idx) begin
               value_in = head_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== rtl/core/ple_ctrl.sv =====
// Controller of the positional list engine: checks positions, keeps the
// entry count, sequences readouts and owns the result register. Uses ple_pkg.
module ple_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   ple_req_if.sink                            req,
   ple_rsp_if.source                          rsp,
   input  logic signed [ple_pkg::VALUE_W-1:0] head_value,
   output ple_pkg::cell_ctrl_type             cell_ctrl
);

   ple_pkg::state_type             state_ff, state_in;
   logic [ple_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [ple_pkg::CNT_W-1:0]      remain_ff, remain_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   ple_pkg::rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic                           slot_free;
   logic                           req_fire;
   logic [ple_pkg::CMP_W-1:0]      pos_ext;
   logic [ple_pkg::CMP_W-1:0]      cnt_ext;
   logic [ple_pkg::CELL_IDX_W-1:0] pos_idx;

   assign pos_ext = ple_pkg::CMP_W'(req.position);
   assign cnt_ext = ple_pkg::CMP_W'(count_ff);
   assign pos_idx = ple_pkg::CELL_IDX_W'(pos_ext - ple_pkg::CMP_W'(1));

   // The output register may be refilled when empty or being drained.
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ple_pkg::ST_IDLE) && slot_free;
   assign req_fire  = req.valid && req.ready;

   // Next state, cell control and the result to load.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      remain_in      = remain_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_data_in    = rsp_data_ff;
      cell_ctrl.op       = ple_pkg::CELL_HOLD;
      cell_ctrl.pos_idx  = pos_idx;
      cell_ctrl.last_idx = ple_pkg::CELL_IDX_W'(count_ff - ple_pkg::CNT_W'(1));
      cell_ctrl.value    = req.item_value;

      unique case (state_ff)
         ple_pkg::ST_IDLE: begin
            if (req_fire) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = ple_pkg::STATUS_INVALID;
               rsp_data_in.read_value   = '0;
               rsp_data_in.last_result  = 1'b1;
               unique case (ple_pkg::cmd_type'(req.cmd))
                  ple_pkg::CMD_INSERT: begin
                     if (count_ff >= ple_pkg::CNT_W'(ple_pkg::DEPTH)) begin
                        rsp_data_in.status = ple_pkg::STATUS_FULL;
                     end else if (pos_ext != '0 &&
                                  pos_ext <= cnt_ext + ple_pkg::CMP_W'(1)) begin
                        rsp_data_in.status = ple_pkg::STATUS_OK;
                        cell_ctrl.op       = ple_pkg::CELL_INSERT;
                        count_in           = count_ff + ple_pkg::CNT_W'(1);
                     end
                  end
                  ple_pkg::CMD_DELETE: begin
                     if (pos_ext != '0 && pos_ext <= cnt_ext) begin
                        rsp_data_in.status = ple_pkg::STATUS_OK;
                        cell_ctrl.op       = ple_pkg::CELL_DELETE;
                        count_in           = count_ff - ple_pkg::CNT_W'(1);
                     end
                  end
                  ple_pkg::CMD_READOUT: begin
                     if (count_ff == '0) begin
                        rsp_data_in.status = ple_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_valid_in = rsp_valid_ff && !rsp.ready;
                        rsp_data_in  = rsp_data_ff;
                        remain_in    = count_ff;
                        state_in     = ple_pkg::ST_READOUT;
                     end
                  end
                  default: rsp_data_in.status = ple_pkg::STATUS_INVALID;
               endcase
               if (state_in == ple_pkg::ST_IDLE) begin
                  rsp_data_in.entry_count = ple_pkg::ENTRY_CNT_W'(count_in);
               end
            end
         end
         ple_pkg::ST_READOUT: begin
            // Emit the head entry and rotate the occupied cells by one.
            if (slot_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.status       = ple_pkg::STATUS_OK;
               rsp_data_in.read_value   = head_value;
               rsp_data_in.entry_count  = ple_pkg::ENTRY_CNT_W'(count_ff);
               rsp_data_in.last_result  = (remain_ff == ple_pkg::CNT_W'(1));
               cell_ctrl.op             = ple_pkg::CELL_ROTATE;
               remain_in                = remain_ff - ple_pkg::CNT_W'(1);
               if (remain_ff == ple_pkg::CNT_W'(1)) begin
                  state_in = ple_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = ple_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ple_pkg::ST_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_data_ff.status;
   assign rsp.read_value  = rsp_data_ff.read_value;
   assign rsp.entry_count = rsp_data_ff.entry_count;
   assign rsp.last_result = rsp_data_ff.last_result;

   // The count never exceeds the capacity of the chain.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ple_pkg::CNT_W'(ple_pkg::DEPTH))
      else $error("entry count above capacity");

   // During a readout the remaining entries lie between one and the count.
   a_remain_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ple_pkg::ST_READOUT |->
         (remain_ff != '0 && remain_ff <= count_ff))
      else $error("readout counter out of range");

   // An insert grows the list by exactly one entry.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      cell_ctrl.op == ple_pkg::CELL_INSERT |=>
         count_ff == $past(count_ff) + ple_pkg::CNT_W'(1))
      else $error("insert did not grow the list");

   // Emitting the final readout entry returns the controller to idle.
   a_readout_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ple_pkg::ST_READOUT && slot_free &&
       remain_ff == ple_pkg::CNT_W'(1)) |=> state_ff == ple_pkg::ST_IDLE)
      else $error("readout did not end after the last entry");

endmodule

// ===== rtl/core/positional_list_engine.sv =====
// Top level of the positional list engine: controller plus a chain of
// storage cells. Depends on ple_pkg, ple_req_if, ple_rsp_if, ple_cell, ple_ctrl.
//
//   Channel   Direction   Carries
//   req_ch    in          cmd, item_value, position
//   rsp_ch    out         status, read_value, entry_count, last_result
//
// Insert, delete and rejected items update the cells and load the result as they
// are taken; every cell shifts at once. A readout holds the input from its
// acceptance until its last entry is emitted, as the occupied cells rotate one
// place toward cell zero per result item; no item is taken meanwhile.
// Synchronous reset empties the list; cell contents are not cleared.
// A stalled rsp_ch holds the result register and pauses the readout rotation.
module positional_list_engine (
   input  logic      clock,
   input  logic      reset,
   ple_req_if.sink   req_ch,
   ple_rsp_if.source rsp_ch
);

   ple_pkg::cell_ctrl_type             cell_ctrl;
   logic signed [ple_pkg::VALUE_W-1:0] cell_values [ple_pkg::DEPTH];

   ple_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .head_value (cell_values[0]),
      .cell_ctrl  (cell_ctrl)
   );

   // Chain of cells; each end reuses its own value as the missing neighbor.
   for (genvar g = 0; g < ple_pkg::DEPTH; g++) begin : g_cell
      logic signed [ple_pkg::VALUE_W-1:0] left_value;
      logic signed [ple_pkg::VALUE_W-1:0] right_value;

      if (g == 0) begin : g_first
         assign left_value = cell_values[g];
      end else begin : g_mid_left
         assign left_value = cell_values[g-1];
      end

      if (g == ple_pkg::DEPTH - 1) begin : g_last
         assign right_value = cell_values[g];
      end else begin : g_mid_right
         assign right_value = cell_values[g+1];
      end

      ple_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .cell_index  (ple_pkg::CELL_IDX_W'(g)),
         .left_value  (left_value),
         .right_value (right_value),
         .head_value  (cell_values[0]),
         .value       (cell_values[g])
      );
   end

endmodule

// ===== tb/sv/tb_positional_list_engine.sv =====
`timescale 1ns / 100ps
// Testbench for positional_list_engine: checks inserts, deletes and readouts
// against an in-bench list model. Depends on ple_pkg, ple_req_if and ple_rsp_if.
module tb_positional_list_engine;

   // Command code that the block does not define; it must be rejected.
   localparam logic [ple_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   // Cycles without any accepted item before the run is declared hung.
   localparam int STALL_LIMIT = 4000;
   // Length of the long receiver hold-off.
   localparam int LONG_HOLD = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   ple_req_if req_ch ();
   ple_rsp_if rsp_ch ();

   positional_list_engine u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Model of the list contents and the results it is owed.
   logic signed [ple_pkg::VALUE_W-1:0] list_cells [ple_pkg::DEPTH];
   int                                 list_len = 0;
   ple_pkg::rsp_payload_type           expected_results [$];

   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int rsp_hold_request = 0;
   int rsp_hold_left = 0;
   int quiet_cycles = 0;

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Apply one accepted command to the list model and queue its results.
   task automatic apply_list_op(input logic [ple_pkg::CMD_W-1:0] op,
                                input logic signed [ple_pkg::VALUE_W-1:0] value,
                                input logic [ple_pkg::POS_W-1:0] pos);
      ple_pkg::rsp_payload_type res;
      int p;
      int i;
      p = int'(pos);
      res = '0;
      res.last_result = 1'b1;
      case (op)
         ple_pkg::CMD_INSERT: begin
            if (list_len >= ple_pkg::DEPTH) begin
               res.status = ple_pkg::STATUS_FULL;
            end else if (p < 1 || p > list_len + 1) begin
               res.status = ple_pkg::STATUS_INVALID;
            end else begin
               for (i = list_len; i > p - 1; i--) list_cells[i] = list_cells[i - 1];
               list_cells[p - 1] = value;
               list_len++;
               res.status = ple_pkg::STATUS_OK;
            end
            res.entry_count = ple_pkg::ENTRY_CNT_W'(list_len);
            expected_results.push_back(res);
         end
         ple_pkg::CMD_DELETE: begin
            if (p < 1 || p > list_len) begin
               res.status = ple_pkg::STATUS_INVALID;
            end else begin
               for (i = p - 1; i + 1 < list_len; i++) list_cells[i] = list_cells[i + 1];
               list_len--;
               res.status = ple_pkg::STATUS_OK;
            end
            res.entry_count = ple_pkg::ENTRY_CNT_W'(list_len);
            expected_results.push_back(res);
         end
         ple_pkg::CMD_READOUT: begin
            if (list_len == 0) begin
               res.status = ple_pkg::STATUS_EMPTY;
               expected_results.push_back(res);
            end else begin
               for (i = 0; i < list_len; i++) begin
                  res.status = ple_pkg::STATUS_OK;
                  res.read_value = list_cells[i];
                  res.entry_count = ple_pkg::ENTRY_CNT_W'(list_len);
                  res.last_result = (i == list_len - 1);
                  expected_results.push_back(res);
               end
            end
         end
         default: begin
            res.status = ple_pkg::STATUS_INVALID;
            res.entry_count = ple_pkg::ENTRY_CNT_W'(list_len);
            expected_results.push_back(res);
         end
      endcase
   endtask

   // Offer one item, idling first at the current sender rate, and wait for it
   // to be taken. Valid stays high so the next item can follow back to back.
   task automatic send_item(input logic [ple_pkg::CMD_W-1:0] op,
                            input logic signed [ple_pkg::VALUE_W-1:0] value,
                            input logic [ple_pkg::POS_W-1:0] pos);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.cmd        <= op;
      req_ch.item_value <= value;
      req_ch.position   <= pos;
      do @(posedge clock); while (!req_ch.ready);
      apply_list_op(op, value, pos);
   endtask

   // Stop offering and wait until every owed result has arrived.
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Item values weighted toward the extremes.
   function automatic logic signed [ple_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return '0;
         3: return -32'sd1;
         4: return $signed($urandom_range(0, 20)) - 10;
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] exp_v,
                                  input logic [31:0] act_v);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
      error_count++;
   endtask

   // Compare every accepted result with the oldest one owed.
   always @(posedge clock) begin
      ple_pkg::rsp_payload_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0h value %0h",
                     $time, rsp_ch.status, rsp_ch.read_value);
            error_count++;
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_ch.status !== exp_r.status)
               report_mismatch("status", 32'(exp_r.status), 32'(rsp_ch.status));
            if (rsp_ch.read_value !== exp_r.read_value)
               report_mismatch("read_value", exp_r.read_value, rsp_ch.read_value);
            if (rsp_ch.entry_count !== exp_r.entry_count)
               report_mismatch("entry_count", 32'(exp_r.entry_count),
                               32'(rsp_ch.entry_count));
            if (rsp_ch.last_result !== exp_r.last_result)
               report_mismatch("last_result", 32'(exp_r.last_result),
                               32'(rsp_ch.last_result));
         end
      end
   end

   // Receiver readiness: random idling, or a long hold-off when requested.
   always @(negedge clock) begin
      if (rsp_hold_request > 0) begin
         rsp_hold_left = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left = rsp_hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("[positional_list_engine] ERROR");
            $finish;
         end
      end
   end

   // Edge positions, extreme values and every rejection path but the full list.
   task automatic test_directed();
      send_item(ple_pkg::CMD_READOUT, '0, 5'd0);
      send_item(ple_pkg::CMD_DELETE, '0, 5'd1);
      send_item(ple_pkg::CMD_INSERT, 32'sd5, 5'd0);
      send_item(ple_pkg::CMD_INSERT, 32'sd6, 5'd2);
      send_item(ple_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 5'd1);
      send_item(ple_pkg::CMD_INSERT, 32'sh8000_0000, 5'd2);
      send_item(ple_pkg::CMD_INSERT, '0, 5'd1);
      send_item(ple_pkg::CMD_INSERT, -32'sd1, 5'd2);
      send_item(ple_pkg::CMD_INSERT, 32'sd7, 5'd6);
      send_item(ple_pkg::CMD_READOUT, -32'sd1, 5'd31);
      send_item(ple_pkg::CMD_DELETE, '0, 5'd0);
      send_item(ple_pkg::CMD_DELETE, '0, 5'd5);
      send_item(ple_pkg::CMD_DELETE, '0, 5'd31);
      send_item(ple_pkg::CMD_DELETE, '0, 5'd2);
      send_item(ple_pkg::CMD_DELETE, '0, 5'd1);
      send_item(ple_pkg::CMD_READOUT, '0, 5'd0);
      send_item(ple_pkg::CMD_DELETE, '0, 5'd2);
      send_item(CMD_UNUSED, 32'sh1234_5678, 5'd1);
      send_item(ple_pkg::CMD_INSERT, 32'sd9, 5'd17);
      send_item(ple_pkg::CMD_DELETE, '0, 5'd1);
      send_item(ple_pkg::CMD_READOUT, '0, 5'd0);
      send_item(ple_pkg::CMD_INSERT, 32'sh5555_AAAA, 5'd1);
      send_item(ple_pkg::CMD_READOUT, '0, 5'd16);
      send_item(ple_pkg::CMD_DELETE, '0, 5'd1);
   endtask

   // Fill the list while the receiver holds off, hit the full case, read it
   // out, then empty it again.
   task automatic test_full_list_backpressure();
      rsp_hold_request = LONG_HOLD;
      while (list_len < ple_pkg::DEPTH)
         send_item(ple_pkg::CMD_INSERT, pick_value(),
                   ple_pkg::POS_W'($urandom_range(1, list_len + 1)));
      send_item(ple_pkg::CMD_INSERT, 32'sd1, 5'd0);
      send_item(ple_pkg::CMD_INSERT, 32'sd2, 5'd17);
      send_item(ple_pkg::CMD_INSERT, 32'sd3, 5'd1);
      send_item(ple_pkg::CMD_READOUT, '0, 5'd0);
      send_item(ple_pkg::CMD_READOUT, '0, 5'd0);
      wait_drained();
      while (list_len > 0)
         send_item(ple_pkg::CMD_DELETE, pick_value(),
                   ple_pkg::POS_W'($urandom_range(1, list_len)));
      send_item(ple_pkg::CMD_READOUT, '0, 5'd0);
      wait_drained();
   endtask

   // Mostly valid edits steered toward a moving fill target, with readouts,
   // bad positions and the unused command mixed in.
   task automatic test_random_ops(input int n_items);
      int k;
      int target;
      int roll;
      target = 0;
      for (k = 0; k < n_items; k++) begin
         if (k % 30 == 0) target = int'($urandom_range(0, ple_pkg::DEPTH));
         roll = int'($urandom_range(0, 99));
         if (roll < 4) begin
            send_item(CMD_UNUSED, pick_value(), ple_pkg::POS_W'($urandom_range(0, 31)));
         end else if (roll < 18) begin
            send_item(ple_pkg::CMD_READOUT, pick_value(),
                      ple_pkg::POS_W'($urandom_range(0, 31)));
         end else if (roll < 30) begin
            send_item($urandom_range(0, 1) ? ple_pkg::CMD_INSERT : ple_pkg::CMD_DELETE,
                      pick_value(),
                      ($urandom_range(0, 3) == 0)
                         ? ple_pkg::POS_W'($urandom_range(0, 31))
                         : ple_pkg::POS_W'($urandom_range(0, ple_pkg::DEPTH + 1)));
         end else if (list_len < target || list_len == 0) begin
            send_item(ple_pkg::CMD_INSERT, pick_value(),
                      ple_pkg::POS_W'($urandom_range(1, list_len + 1)));
         end else begin
            send_item(ple_pkg::CMD_DELETE, pick_value(),
                      ple_pkg::POS_W'($urandom_range(1, list_len)));
         end
      end
      wait_drained();
   endtask

   // Test sequence.
   initial begin
      req_ch.valid      = 1'b0;
      req_ch.cmd        = ple_pkg::CMD_INSERT;
      req_ch.item_value = '0;
      req_ch.position   = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 26;
      recv_idle_pct = 56;
      test_directed();
      wait_drained();
      test_full_list_backpressure();
      test_random_ops(100);

      send_idle_pct = 56;
      recv_idle_pct = 26;
      test_random_ops(100);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_ops(100);

      repeat (32) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_results.size());
         error_count++;
      end
      if (error_count == 0)
         $display("[positional_list_engine] OK");
      else
         $display("[positional_list_engine] ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/ple_pkg.sv
rtl/core/ple_req_if.sv
rtl/core/ple_rsp_if.sv
rtl/core/ple_cell.sv
rtl/core/ple_ctrl.sv
rtl/core/positional_list_engine.sv
tb/sv/tb_positional_list_engine.sv
